/* sv/bcc_pkg.sv */
// package: shared types and constants for the coulomb counter
package bcc_pkg;

  localparam int unsigned MaxSamplesDefault = 65535;

  localparam int unsigned CntW  = 16;
  localparam int unsigned VSumW = 32;
  localparam int unsigned ISumW = 33;
  localparam int unsigned PSumW = 36;
  localparam int unsigned DivW  = 36;

  // input item kinds
  typedef enum logic [1:0] {
    KIND_SAMPLE    = 2'd0,
    KIND_CLOSE     = 2'd1,
    KIND_CLR_CHG   = 2'd2,
    KIND_CLR_MARKS = 2'd3
  } kind_e;

  // config register indexes
  localparam logic [0:0] REG_OFFSET   = 1'b0;
  localparam logic [0:0] REG_DEADZONE = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic       load;      // capture input request
    logic       apply;     // sample / clear update
    logic       div_init;  // start divider on selected sum
    logic [1:0] div_sel;   // 0 voltage, 1 current, 2 power
    logic       div_step;  // one quotient bit
    logic       div_store; // latch quotient
    logic       fin_avg;   // offset and deadzone
    logic       mul_init;
    logic       mul_step;
    logic       fin_chg;   // charge total update
    logic       out_load;  // capture result
  } bcc_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
  } bcc_sts_t;

endpackage

/* sv/bcc_ctrl.sv */
// file: controller state machine of the coulomb counter
module bcc_ctrl import bcc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  bcc_sts_t sts_i,
  output bcc_cmd_t cmd_o
);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b00000001,
    ST_DEC   = 8'b00000010,
    ST_DINIT = 8'b00000100,
    ST_DIV   = 8'b00001000,
    ST_AVG   = 8'b00010000,
    ST_MUL   = 8'b00100000,
    ST_CHG   = 8'b01000000,
    ST_OUT   = 8'b10000000
  } state_e;

  state_e     state_q, state_d;
  logic [5:0] cnt_q, cnt_d;
  logic [1:0] sel_q, sel_d;
  logic       ov_q, ov_d;

  // output holding register flag
  always_comb begin
    ov_d = ov_q;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    if (cmd_o.out_load) ov_d = 1'b1;
  end

  // sequencing
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    sel_d   = sel_q;
    cmd_o   = '0;
    cmd_o.div_sel = sel_q;
    in_ready_o = (state_q == ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = ST_DEC;
        end
      end
      ST_DEC: begin
        if (sts_i.kind == KIND_CLOSE) begin
          sel_d = 2'd0;
          state_d = ST_DINIT;
        end else begin
          cmd_o.apply = 1'b1;
          state_d = ST_OUT;
        end
      end
      ST_DINIT: begin
        cmd_o.div_init = 1'b1;
        cnt_d = 6'(DivW - 1);
        state_d = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == '0) begin
          cmd_o.div_store = 1'b1;
          if (sel_q == 2'd2) state_d = ST_AVG;
          else begin
            sel_d = sel_q + 2'd1;
            state_d = ST_DINIT;
          end
        end
      end
      ST_AVG: begin
        cmd_o.fin_avg = 1'b1;
        state_d = ST_MUL;
        cmd_o.mul_init = 1'b1;
        cnt_d = 6'd31;
      end
      ST_MUL: begin
        cmd_o.mul_step = 1'b1;
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == '0) state_d = ST_CHG;
      end
      ST_CHG: begin
        cmd_o.fin_chg = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!ov_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      sel_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      sel_q   <= sel_d;
      ov_q    <= ov_d;
    end
  end

  assign out_valid_o = ov_q;

endmodule

/* sv/bcc_dp.sv */
// file: datapath of the coulomb counter (sums, serial divider, serial multiplier)
module bcc_dp import bcc_pkg::*; #(
  parameter int unsigned MaxSamples = MaxSamplesDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  bcc_cmd_t     cmd_i,
  output bcc_sts_t     sts_o,
  input  logic [85:0]  in_data_i,
  input  logic         cfg_valid_i,
  input  logic [0:0]   cfg_index_i,
  input  logic [15:0]  cfg_data_i,
  output logic [247:0] out_data_o
);

  // captured request
  logic [1:0]  kind_q;
  logic [14:0] volt_q;
  logic signed [15:0] curr_q;
  logic [19:0] pwr_q;
  logic        rdy_q;
  logic [31:0] el_q;

  // config
  logic signed [15:0] off_q;
  logic [9:0]         dz_q;

  // state
  logic [VSumW-1:0]        vsum_q;
  logic signed [ISumW-1:0] isum_q;
  logic [PSumW-1:0]        psum_q;
  logic [CntW-1:0]         cnt_q;
  logic [14:0]             avv_q;
  logic signed [16:0]      avi_q;
  logic [19:0]             avp_q;
  logic signed [48:0]      cl_q;
  logic signed [63:0]      ct_q;
  logic [14:0]             vmin_q, vmax_q;
  logic signed [15:0]      imin_q, imax_q;
  logic                    acc_q;

  // divider
  logic [DivW-1:0] dq_q, dr_q;
  logic            dneg_q;
  logic [DivW:0]   dtrial;
  logic [DivW-1:0] qv_q, qi_q, qp_q;
  logic [DivW-1:0] qnext;
  logic [DivW-1:0] qmag;
  logic signed [DivW-1:0] isum_ext;

  // multiplier
  logic [48:0] prod_q;
  logic [31:0] mcand_q;
  logic [16:0] mabs_q;
  logic        mneg_q;

  logic signed [17:0] ac_w;
  logic [17:0]        ac_mag;
  logic signed [48:0] chg_w;
  logic signed [64:0] sum65;
  logic take;

  assign sts_o.kind = kind_q;
  assign take = (kind_q == KIND_SAMPLE) && rdy_q && (32'(cnt_q) < 32'(MaxSamples));
  assign isum_ext = DivW'(isum_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= in_data_i[1:0];
      volt_q <= in_data_i[16:2];
      curr_q <= in_data_i[32:17];
      pwr_q  <= in_data_i[52:33];
      rdy_q  <= in_data_i[53];
      el_q   <= in_data_i[85:54];
    end
  end

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q <= '0;
      dz_q  <= 10'd10;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_OFFSET) off_q <= cfg_data_i;
      else dz_q <= cfg_data_i[9:0];
    end
  end

  // restoring divider, magnitude form
  assign dtrial = {dr_q, dq_q[DivW-1]} - {{(DivW+1-CntW){1'b0}}, cnt_q};
  assign qnext  = {dq_q[DivW-2:0], ~dtrial[DivW]};
  assign qmag   = dneg_q ? (~qnext + 1'b1) : qnext;

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      dr_q <= '0;
      unique case (cmd_i.div_sel)
        2'd0: begin dq_q <= DivW'(vsum_q); dneg_q <= 1'b0; end
        2'd1: begin
          dneg_q <= isum_q[ISumW-1];
          dq_q   <= isum_q[ISumW-1] ? (~isum_ext + 1'b1) : isum_ext;
        end
        default: begin dq_q <= psum_q; dneg_q <= 1'b0; end
      endcase
    end else if (cmd_i.div_step) begin
      if (!dtrial[DivW]) begin
        dr_q <= dtrial[DivW-1:0];
        dq_q <= {dq_q[DivW-2:0], 1'b1};
      end else begin
        dr_q <= {dr_q[DivW-2:0], dq_q[DivW-1]};
        dq_q <= {dq_q[DivW-2:0], 1'b0};
      end
    end
  end

  // quotient capture on the last step, last bit included; zero count gives zero
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_store) begin
      unique case (cmd_i.div_sel)
        2'd0: qv_q <= (cnt_q == '0) ? '0 : qmag;
        2'd1: qi_q <= (cnt_q == '0) ? '0 : qmag;
        default: qp_q <= (cnt_q == '0) ? '0 : qmag;
      endcase
    end
  end

  // average current with offset, its magnitude, signed charge and saturating sum
  assign ac_w   = 18'(signed'(qi_q[16:0])) + 18'(off_q);
  assign ac_mag = ac_w[17] ? (~ac_w + 1'b1) : ac_w;
  assign chg_w  = mneg_q ? (~prod_q + 1'b1) : prod_q;
  assign sum65  = 65'(ct_q) + 65'(chg_w);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_init) begin
      prod_q  <= '0;
      mcand_q <= el_q;
      mabs_q  <= (ac_mag < 18'(dz_q)) ? 17'd0 : ac_mag[16:0];
      mneg_q  <= ac_w[17];
    end else if (cmd_i.mul_step) begin
      prod_q  <= (prod_q << 1) + (mcand_q[31] ? 49'(mabs_q) : 49'd0);
      mcand_q <= mcand_q << 1;
    end
  end

  // architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vsum_q <= '0; isum_q <= '0; psum_q <= '0; cnt_q <= '0;
      avv_q <= '0; avi_q <= '0; avp_q <= '0; cl_q <= '0; ct_q <= '0;
      vmin_q <= 15'h7fff; vmax_q <= '0;
      imin_q <= 16'sh7fff; imax_q <= 16'sh8000;
      acc_q <= 1'b0;
    end else begin
      if (cmd_i.apply) begin
        acc_q <= take;
        unique case (kind_e'(kind_q))
          KIND_SAMPLE: begin
            if (take) begin
              vsum_q <= vsum_q + VSumW'(volt_q);
              isum_q <= isum_q + ISumW'(curr_q);
              psum_q <= psum_q + PSumW'(pwr_q);
              cnt_q  <= cnt_q + 1'b1;
              if (volt_q < vmin_q) vmin_q <= volt_q;
              if (volt_q > vmax_q) vmax_q <= volt_q;
              if (curr_q < imin_q) imin_q <= curr_q;
              if (curr_q > imax_q) imax_q <= curr_q;
            end
          end
          KIND_CLR_CHG: ct_q <= '0;
          KIND_CLR_MARKS: begin
            vmin_q <= 15'h7fff; vmax_q <= '0;
            imin_q <= 16'sh7fff; imax_q <= 16'sh8000;
          end
          default: ;
        endcase
      end
      if (cmd_i.fin_avg) begin
        acc_q <= 1'b0;
        avv_q <= qv_q[14:0];
        if (ac_mag < 18'(dz_q)) begin
          avi_q <= '0; avp_q <= '0;
        end else begin
          avi_q <= ac_w[16:0]; avp_q <= qp_q[19:0];
        end
      end
      if (cmd_i.fin_chg) begin
        cl_q <= chg_w;
        if (sum65[64] != sum65[63])
          ct_q <= sum65[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        else ct_q <= sum65[63:0];
        vsum_q <= '0; isum_q <= '0; psum_q <= '0; cnt_q <= '0;
      end
    end
  end

  logic signed [16:0] amin_w, amax_w;
  assign amin_w = 17'(imin_q) + 17'(off_q);
  assign amax_w = 17'(imax_q) + 17'(off_q);

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_o <= {2'b00, acc_q, cnt_q, amax_w, amin_w, vmax_q, vmin_q,
                     ct_q, cl_q, avp_q, avi_q, avv_q};
    end
  end

endmodule

/* sv/battery_coulomb_counter.sv */
// file: top level of the window-averaging coulomb counter
// sequence: a sample or clear request is decoded, applied and registered as its result;
// a close window request runs decode, three serial divisions (setup plus 36 steps each),
// average, a shift-add multiply, charge and output
// flow: one request at a time; the next is accepted once the previous result is loaded
// into the output register, which waits while the result before it is still unread
// reset: asynchronous active low; sums, averages and charge clear, watermarks go to
// their extremes, offset 0 and deadzone 10
module battery_coulomb_counter import bcc_pkg::*; #(
  parameter int unsigned MaxSamples = MaxSamplesDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // bus_voltage_mv, current_ma, power_mw, sample_ready, elapsed_us, zero pad
  input  logic [87:0]  s_axis_tdata,
  // kind
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // avg_voltage_mv, avg_current_ma, avg_power_mw, charge_last, charge_total,
  // volt_min_mv, volt_max_mv, amp_min_ma, amp_max_ma, window_samples, accepted, pad
  output logic [247:0] m_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [0:0]   cfg_index_i,
  input  logic [15:0]  cfg_data_i
);

  bcc_cmd_t     cmd;
  bcc_sts_t     sts;

  assign cfg_ready_o  = 1'b1;

  bcc_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid), .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .sts_i(sts), .cmd_o(cmd)
  );

  bcc_dp #(.MaxSamples(MaxSamples)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .in_data_i({s_axis_tdata[83:0], s_axis_tuser}),
    .cfg_valid_i, .cfg_index_i, .cfg_data_i,
    .out_data_o(m_axis_tdata)
  );

endmodule

/* sv/bcc_checker.sv */
// file: port-level checker for the coulomb counter
module bcc_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [247:0] m_axis_tdata
);

  // result stays until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");

  // one request in flight: no accept right after an accept
  a_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("back to back accept");

  // an accumulated sample leaves a nonzero window count
  a_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[245] |-> m_axis_tdata[244:229] != 16'd0)
    else $error("accepted with empty window");

endmodule

bind battery_coulomb_counter bcc_checker u_bcc_checker (.*);

/* sim/testbench.sv */
// testbench for the window-averaging coulomb counter: directed table, random requests, predictor
`timescale 1ns / 100ps

module testbench;
  import bcc_pkg::*;

  // one input request
  typedef struct {
    kind_e       kind;
    logic [14:0] volt;
    logic [15:0] curr;
    logic [19:0] pwr;
    logic        rdy;
    logic [31:0] elapsed;
  } meas_t;

  // one result, packed from the top bit of the used tdata range down
  typedef struct packed {
    logic        accepted;
    logic [15:0] window_samples;
    logic [16:0] amp_max;
    logic [16:0] amp_min;
    logic [14:0] volt_max;
    logic [14:0] volt_min;
    logic [63:0] charge_total;
    logic [48:0] charge_last;
    logic [19:0] avg_power;
    logic [16:0] avg_current;
    logic [14:0] avg_voltage;
  } gauge_t;

  // directed row: request plus an optional typed-in result
  typedef struct {
    meas_t  m;
    bit     fixed;
    gauge_t g;
  } row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [87:0]  s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [247:0] m_axis_tdata;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [0:0]   cfg_index_i = REG_OFFSET;
  logic [15:0]  cfg_data_i = '0;

  battery_coulomb_counter dut (.*);

  always #5 clk_i = ~clk_i;

  // predictor copy of the counter state
  longint offset_ma, deadzone;
  longint vsum, isum, psum, count;
  longint avg_v, avg_i, avg_p, chg_last, chg_total;
  longint vmin, vmax, imin, imax;

  gauge_t gauge_q[$];
  int     errors = 0;
  int     sink_hold = 0;
  bit     idle_gaps = 1'b1;

  function automatic gauge_t next_gauge(meas_t m);
    gauge_t g;
    longint cur, av, ai, ap, mag, prod;
    bit acc;
    acc = 1'b0;
    cur = longint'($signed(m.curr));
    case (m.kind)
      KIND_SAMPLE: begin
        if (m.rdy && count < MaxSamplesDefault) begin
          vsum += m.volt;
          isum += cur;
          psum += m.pwr;
          if (m.volt < vmin) vmin = m.volt;
          if (m.volt > vmax) vmax = m.volt;
          if (cur < imin) imin = cur;
          if (cur > imax) imax = cur;
          count++;
          acc = 1'b1;
        end
      end
      KIND_CLOSE: begin
        av = 0;
        ai = 0;
        ap = 0;
        // empty window divides to zero
        if (count != 0) begin
          av = vsum / count;
          ai = isum / count;
          ap = psum / count;
        end
        ai += offset_ma;
        mag = (ai < 0) ? -ai : ai;
        if (mag < deadzone) begin
          ai = 0;
          ap = 0;
        end
        avg_v = av;
        avg_i = ai;
        avg_p = ap;
        prod = ai * longint'({32'd0, m.elapsed});
        chg_last = prod;
        // saturating charge total
        if (prod > 0 && chg_total > 64'sh7FFF_FFFF_FFFF_FFFF - prod)
          chg_total = 64'sh7FFF_FFFF_FFFF_FFFF;
        else if (prod < 0 && chg_total < 64'sh8000_0000_0000_0000 - prod)
          chg_total = 64'sh8000_0000_0000_0000;
        else
          chg_total += prod;
        vsum = 0;
        isum = 0;
        psum = 0;
        count = 0;
      end
      KIND_CLR_CHG: chg_total = 0;
      default: begin
        vmin = 32767;
        vmax = 0;
        imin = 32767;
        imax = -32768;
      end
    endcase
    g.avg_voltage    = avg_v[14:0];
    g.avg_current    = avg_i[16:0];
    g.avg_power      = avg_p[19:0];
    g.charge_last    = chg_last[48:0];
    g.charge_total   = chg_total;
    g.volt_min       = vmin[14:0];
    g.volt_max       = vmax[14:0];
    cur              = imin + offset_ma;
    g.amp_min        = cur[16:0];
    cur              = imax + offset_ma;
    g.amp_max        = cur[16:0];
    g.window_samples = count[15:0];
    g.accepted       = acc;
    return g;
  endfunction

  function automatic meas_t mk(kind_e k, int v, int c, int p, bit r, logic [31:0] e);
    meas_t m;
    m.kind = k;
    m.volt = v[14:0];
    m.curr = c[15:0];
    m.pwr = p[19:0];
    m.rdy = r;
    m.elapsed = e;
    return m;
  endfunction

  function automatic meas_t rand_meas();
    meas_t m;
    int sel;
    sel = $urandom_range(99);
    m.kind = (sel < 74) ? KIND_SAMPLE : (sel < 90) ? KIND_CLOSE :
             (sel < 95) ? KIND_CLR_CHG : KIND_CLR_MARKS;
    m.volt = ($urandom_range(9) == 0) ? ($urandom_range(1) ? 15'h7FFF : 15'h0)
                                      : 15'($urandom);
    // small currents now and then so the deadzone gets exercised
    m.curr = ($urandom_range(3) == 0) ? 16'($signed($urandom_range(40)) - 20)
                                      : 16'($urandom);
    m.pwr = 20'($urandom);
    m.rdy = ($urandom_range(7) != 0);
    m.elapsed = $urandom_range(2) == 0 ? $urandom_range(2000) : $urandom;
    return m;
  endfunction

  // source side: random gap, offer, wait for the handshake
  task automatic send_meas(meas_t m, bit fixed = 1'b0, gauge_t g = '0);
    int gap;
    gauge_t p;
    gap = 0;
    if (idle_gaps && $urandom_range(3) == 0)
      gap = ($urandom_range(15) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= m.kind;
    s_axis_tdata <= {4'b0000, m.elapsed, m.rdy, m.pwr, m.curr, m.volt};
    do @(posedge clk_i); while (!s_axis_tready);
    p = next_gauge(m);
    gauge_q.push_back(fixed ? g : p);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (gauge_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [15:0] data);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == REG_OFFSET) offset_ma = longint'($signed(data));
    else deadzone = data[9:0];
  endtask

  task automatic run_random(int n);
    repeat (n) send_meas(rand_meas());
  endtask

  task automatic field_chk(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= 10)
        $display("mismatch %s: expected %h got %h", name, want, got);
    end
  endtask

  // sink side: check each result, then pick the next ready level
  always @(posedge clk_i) begin
    gauge_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[245:0];
      if (gauge_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("mismatch: result with nothing pending");
      end else begin
        want = gauge_q.pop_front();
        field_chk("avg_voltage", want.avg_voltage, got.avg_voltage);
        field_chk("avg_current", want.avg_current, got.avg_current);
        field_chk("avg_power", want.avg_power, got.avg_power);
        field_chk("charge_last", want.charge_last, got.charge_last);
        field_chk("charge_total", want.charge_total, got.charge_total);
        field_chk("volt_min", want.volt_min, got.volt_min);
        field_chk("volt_max", want.volt_max, got.volt_max);
        field_chk("amp_min", want.amp_min, got.amp_min);
        field_chk("amp_max", want.amp_max, got.amp_max);
        field_chk("window_samples", want.window_samples, got.window_samples);
        field_chk("accepted", want.accepted, got.accepted);
      end
    end
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
      m_axis_tready <= 1'b0;
    end else if (idle_gaps && $urandom_range(7) == 0) begin
      sink_hold <= ($urandom_range(9) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 2);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // run limit
  initial begin
    #30ms;
    $display("FAIL");
    $finish;
  end

  initial begin
    row_t   rows[$];
    row_t   r;
    gauge_t idle_g;
    offset_ma = 0;
    deadzone = 10;
    vsum = 0; isum = 0; psum = 0; count = 0;
    avg_v = 0; avg_i = 0; avg_p = 0; chg_last = 0; chg_total = 0;
    vmin = 32767; vmax = 0; imin = 32767; imax = -32768;

    // state right after reset, readable at a glance
    idle_g = '0;
    idle_g.volt_min = 15'h7FFF;
    idle_g.amp_min = 17'h07FFF;
    idle_g.amp_max = 17'h18000;

    r.fixed = 1'b1; r.g = idle_g;
    r.m = mk(KIND_CLOSE, 0, 0, 0, 0, 32'hFFFF_FFFF); rows.push_back(r);
    r.m = mk(KIND_SAMPLE, 32767, 32767, 20'hFFFFF, 0, 0); rows.push_back(r);
    r.m = mk(KIND_CLR_MARKS, 5, 5, 5, 1, 7); rows.push_back(r);
    r.fixed = 1'b0;
    r.m = mk(KIND_SAMPLE, 32767, 32767, 20'hFFFFF, 1, 32'hFFFF_FFFF); rows.push_back(r);
    r.m = mk(KIND_SAMPLE, 0, -32768, 0, 1, 0); rows.push_back(r);
    r.m = mk(KIND_SAMPLE, 100, 100, 100, 0, 0); rows.push_back(r);
    r.m = mk(KIND_CLOSE, 32767, -1, 20'hFFFFF, 1, 32'hFFFF_FFFF); rows.push_back(r);
    r.m = mk(KIND_CLR_CHG, 1234, 55, 9, 1, 32'hFFFF_FFFF); rows.push_back(r);
    r.m = mk(KIND_SAMPLE, 1234, -500, 2000, 1, 0); rows.push_back(r);
    r.m = mk(KIND_SAMPLE, 4321, -7, 17, 1, 0); rows.push_back(r);
    r.m = mk(KIND_CLOSE, 0, 0, 0, 0, 1000); rows.push_back(r);
    r.m = mk(KIND_SAMPLE, 3000, 5, 50, 1, 0); rows.push_back(r);
    r.m = mk(KIND_SAMPLE, 3001, -3, 40, 1, 0); rows.push_back(r);
    r.m = mk(KIND_CLOSE, 0, 0, 0, 0, 100); rows.push_back(r);
    r.m = mk(KIND_CLR_MARKS, 0, 0, 0, 0, 0); rows.push_back(r);
    r.m = mk(KIND_SAMPLE, 16384, 32767, 1, 1, 0); rows.push_back(r);
    r.m = mk(KIND_SAMPLE, 16383, 32766, 3, 1, 0); rows.push_back(r);
    r.m = mk(KIND_CLOSE, 0, 0, 0, 0, 32'hFFFF_FFFF); rows.push_back(r);
    r.m = mk(KIND_CLOSE, 0, 0, 0, 0, 12345); rows.push_back(r);
    r.m = mk(KIND_CLR_CHG, 0, 0, 0, 0, 0); rows.push_back(r);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_meas(rows[i].m, rows[i].fixed, rows[i].g);
    run_random(300);

    // offset and deadzone extremes
    write_reg(REG_OFFSET, 16'h7FFF);
    write_reg(REG_DEADZONE, 16'd1023);
    run_random(300);
    write_reg(REG_OFFSET, 16'h8000);
    write_reg(REG_DEADZONE, 16'd0);
    run_random(300);
    write_reg(REG_OFFSET, 16'($urandom));
    write_reg(REG_DEADZONE, 16'($urandom));

    // long sink stall while requests keep coming
    sink_hold = 400;
    run_random(350);
    wait_drained();
    run_random(350);

    // back to default settings, close the window and finish with a few more
    write_reg(REG_OFFSET, 16'h0);
    write_reg(REG_DEADZONE, 16'd10);
    send_meas(mk(KIND_CLOSE, 0, 0, 0, 0, 0));
    run_random(20);

    wait_drained();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
sv/bcc_pkg.sv
sv/bcc_ctrl.sv
sv/bcc_dp.sv
sv/battery_coulomb_counter.sv
sv/bcc_checker.sv
sim/testbench.sv
